@@ design/psm_pkg.sv @@
// psm_pkg: shared types and constants for the pooled mean/sd merge block.
// Used by psm_mac, psm_dsq and pooled_mean_sd_merge. No dependencies.
package psm_pkg;

  localparam int FIELD_W   = 32;
  localparam int LIMB_W    = 33;
  localparam int NUM_LIMBS = 4;
  localparam int WIDE_W    = LIMB_W * NUM_LIMBS;   // 132
  localparam int PROD_W    = 2 * LIMB_W;           // 66
  localparam int DEN_W     = 66;
  localparam int ROOT_W    = 32;
  localparam int SQ_W      = 64;
  localparam int TDATA_W   = 3 * FIELD_W;

  localparam logic [FIELD_W-1:0] MEAN_FLIP = 32'h8000_0000;
  localparam logic [FIELD_W-1:0] CNT_MAX   = 32'hFFFF_FFFF;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SXSQ,   // sx*sx
    ST_SXW,    // * (nx-1)
    ST_SYSQ,   // sy*sy
    ST_SYW,    // * (ny-1), accumulate
    ST_SCN,    // * n
    ST_DSQ,    // d*d
    ST_DNX,    // * nx
    ST_DNY,    // * ny, accumulate
    ST_DEN,    // n*(n-1)
    ST_DIVV,   // variance divide
    ST_SQRT,
    ST_MX,     // ux*nx
    ST_MY,     // uy*ny, accumulate
    ST_DIVM,   // mean divide
    ST_OUT
  } state_t;

  typedef enum logic {
    DSQ_DIV,
    DSQ_SQRT
  } dsq_mode_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

@@ design/psm_mac.sv @@
// psm_mac: limb-serial multiply-accumulate, p = init + x*y.
// One 33x33 multiplier, registered product, one 132-bit add per cycle. Uses psm_pkg.
module psm_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [psm_pkg::WIDE_W-1:0]    x,
  input  logic [psm_pkg::LIMB_W-1:0]    y,
  input  logic [psm_pkg::WIDE_W-1:0]    init,
  output logic [psm_pkg::WIDE_W-1:0]    p,
  output psm_pkg::unit_sts_t            sts
);

  logic                          busy_r;
  logic                          done_r;
  logic [2:0]                    cnt_r;
  logic [1:0]                    sh_r;
  logic [psm_pkg::WIDE_W-1:0]    x_r;
  logic [psm_pkg::LIMB_W-1:0]    y_r;
  logic [psm_pkg::PROD_W-1:0]    prod_r;
  logic [psm_pkg::WIDE_W-1:0]    acc_r;
  logic [psm_pkg::LIMB_W-1:0]    limb;
  logic [psm_pkg::PROD_W-1:0]    mul_p;
  logic [psm_pkg::WIDE_W-1:0]    prod_sh;

  assign limb    = x_r[psm_pkg::LIMB_W*cnt_r[1:0] +: psm_pkg::LIMB_W];
  assign mul_p   = psm_pkg::PROD_W'(limb) * psm_pkg::PROD_W'(y_r);
  assign prod_sh = psm_pkg::WIDE_W'(prod_r) << (psm_pkg::LIMB_W * sh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'(psm_pkg::NUM_LIMBS)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // product of limb k is registered in prod_r and added in on the next cycle at limb offset k
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= init;
      x_r   <= x;
      y_r   <= y;
    end else if (busy_r) begin
      if (cnt_r < 3'(psm_pkg::NUM_LIMBS)) begin
        prod_r <= mul_p;
        sh_r   <= cnt_r[1:0];
      end
      if (cnt_r != 3'd0) begin
        acc_r <= acc_r + prod_sh;
      end
    end
  end

  assign p        = acc_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

@@ design/psm_dsq.sv @@
// psm_dsq: bit-serial restoring divider (132/66) and integer square root (64 bit).
// One step per cycle. Uses psm_pkg.
module psm_dsq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  psm_pkg::dsq_mode_t            mode,
  input  logic [psm_pkg::WIDE_W-1:0]    num,
  input  logic [psm_pkg::DEN_W-1:0]     den,
  output logic [psm_pkg::WIDE_W-1:0]    q,
  output logic [psm_pkg::ROOT_W-1:0]    root,
  output psm_pkg::unit_sts_t            sts
);

  logic                          busy_r;
  logic                          done_r;
  psm_pkg::dsq_mode_t            mode_r;
  logic [7:0]                    cnt_r;
  logic [psm_pkg::WIDE_W-1:0]    num_r;
  logic [psm_pkg::DEN_W:0]       rem_r;
  logic [psm_pkg::DEN_W-1:0]     den_r;
  logic [psm_pkg::SQ_W-1:0]      v_r;
  logic [psm_pkg::SQ_W-1:0]      res_r;
  logic [psm_pkg::SQ_W-1:0]      bit_r;
  logic [psm_pkg::DEN_W:0]       rem_sh;
  logic                          div_ge;
  logic [psm_pkg::SQ_W-1:0]      trial;
  logic                          sq_ge;

  assign rem_sh = {rem_r[psm_pkg::DEN_W-1:0], num_r[psm_pkg::WIDE_W-1]};
  assign div_ge = rem_sh >= {1'b0, den_r};
  assign trial  = res_r + bit_r;
  assign sq_ge  = v_r >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= (mode == psm_pkg::DSQ_DIV) ? 8'(psm_pkg::WIDE_W - 1)
                                             : 8'(psm_pkg::ROOT_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 8'd1;
        if (cnt_r == 8'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_r <= mode;
      num_r  <= num;
      den_r  <= den;
      rem_r  <= '0;
      v_r    <= num[psm_pkg::SQ_W-1:0];
      res_r  <= '0;
      bit_r  <= psm_pkg::SQ_W'(1) << (psm_pkg::SQ_W - 2);
    end else if (busy_r) begin
      if (mode_r == psm_pkg::DSQ_DIV) begin
        // quotient bits shift in behind the dividend
        num_r <= {num_r[psm_pkg::WIDE_W-2:0], div_ge};
        rem_r <= div_ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      end else begin
        if (sq_ge) begin
          v_r   <= v_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
    end
  end

  assign q        = num_r;
  assign root     = res_r[psm_pkg::ROOT_W-1:0];
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

@@ design/pooled_mean_sd_merge.sv @@
// pooled_mean_sd_merge: top level, sequencer and state of the group merger.
// Instantiates psm_mac and psm_dsq; types and constants from psm_pkg.
//
// Merges summarized groups (mean, sample sd, count) into a running summary
// using the pooled sample variance. The first group of a sequence loads the
// running values: the sequencer goes from idle to ST_OUT, which registers
// the result and returns to idle once the output register is free.
// Every later group runs a fixed micro-sequence: eleven multiply steps on the
// limb-serial multiplier, two 132-step divisions and a 32-step square root
// on the bit-serial divide/root unit, which works one bit per cycle and
// takes most of the time of a merge. in_tready is high only while the
// sequencer is idle; a finished result waits in the output register, and
// the next transfer is taken while it waits. The mean is rounded to nearest
// (ties up), the sd is floored and saturates at all ones, the count
// saturates at all ones and raises out_tuser. A result with tlast set
// clears the running state. Widths are fixed; the fixed-point scale does
// not change the computed bits.
module pooled_mean_sd_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [psm_pkg::TDATA_W-1:0]   in_tdata,   // group_mean, group_sd, group_count
  input  logic                          in_tlast,   // last_group
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [psm_pkg::TDATA_W-1:0]   out_tdata,  // merged_mean, merged_sd, merged_count
  output logic                          out_tlast,  // final_result
  output logic                          out_tuser   // count_saturated
);

  localparam int FW = psm_pkg::FIELD_W;
  localparam int WW = psm_pkg::WIDE_W;
  localparam int LW = psm_pkg::LIMB_W;

  psm_pkg::state_t state_r, state_nxt;

  logic            issued_r;
  logic [FW-1:0]   gm_r, gs_r, gc_r;
  logic            last_r;
  logic            load_r;
  logic [FW-1:0]   run_mean_r, run_sd_r, run_count_r;
  logic            have_r;
  logic [WW-1:0]   ra_r, rt_r;
  logic [FW-1:0]   sd_new_r, mean_new_r;
  logic            out_valid_r;
  logic [psm_pkg::TDATA_W-1:0] out_data_r;
  logic            out_last_r, out_sat_r;

  logic            in_xfer, out_xfer, out_free;
  logic [LW-1:0]   nx, ny, n, nx_m1, ny_m1, n_m1, diff, dmag;
  logic [FW-1:0]   ux, uy;
  logic [FW-1:0]   fin_mean, fin_sd, fin_count;

  // shared unit hookup
  logic            mac_start, dsq_start, step_done;
  logic [WW-1:0]   mac_x, mac_init, mac_p;
  logic [LW-1:0]   mac_y;
  psm_pkg::dsq_mode_t dsq_mode;
  logic [WW-1:0]   dsq_num, dsq_q;
  logic [psm_pkg::DEN_W-1:0] dsq_den;
  logic [psm_pkg::ROOT_W-1:0] dsq_root;
  psm_pkg::unit_sts_t mac_sts, dsq_sts;

  assign in_tready = (state_r == psm_pkg::ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_valid_r && out_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign nx    = {1'b0, run_count_r};
  assign ny    = {1'b0, gc_r};
  assign n     = nx + ny;
  assign nx_m1 = (run_count_r == '0) ? '0 : nx - LW'(1);
  assign ny_m1 = (gc_r == '0) ? '0 : ny - LW'(1);
  assign n_m1  = n - LW'(1);
  // means in offset binary
  assign ux    = run_mean_r ^ psm_pkg::MEAN_FLIP;
  assign uy    = gm_r ^ psm_pkg::MEAN_FLIP;
  assign diff  = {1'b0, ux} - {1'b0, uy};
  assign dmag  = diff[LW-1] ? (LW'(0) - diff) : diff;

  assign fin_mean  = load_r ? gm_r : mean_new_r;
  assign fin_sd    = load_r ? gs_r : sd_new_r;
  assign fin_count = load_r ? gc_r : (n[LW-1] ? psm_pkg::CNT_MAX : n[FW-1:0]);

  psm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_start),
    .x     (mac_x),
    .y     (mac_y),
    .init  (mac_init),
    .p     (mac_p),
    .sts   (mac_sts)
  );

  psm_dsq u_dsq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dsq_start),
    .mode  (dsq_mode),
    .num   (dsq_num),
    .den   (dsq_den),
    .q     (dsq_q),
    .root  (dsq_root),
    .sts   (dsq_sts)
  );

  // operand selection and unit starts
  always_comb begin
    mac_start = 1'b0;
    mac_x     = '0;
    mac_y     = '0;
    mac_init  = '0;
    dsq_start = 1'b0;
    dsq_mode  = psm_pkg::DSQ_DIV;
    dsq_num   = '0;
    dsq_den   = '0;
    step_done = 1'b0;
    case (state_r)
      psm_pkg::ST_SXSQ: begin
        mac_x = WW'(run_sd_r);
        mac_y = LW'(run_sd_r);
      end
      psm_pkg::ST_SXW: begin
        mac_x = rt_r;
        mac_y = nx_m1;
      end
      psm_pkg::ST_SYSQ: begin
        mac_x = WW'(gs_r);
        mac_y = LW'(gs_r);
      end
      psm_pkg::ST_SYW: begin
        mac_x    = rt_r;
        mac_y    = ny_m1;
        mac_init = ra_r;
      end
      psm_pkg::ST_SCN: begin
        mac_x = ra_r;
        mac_y = n;
      end
      psm_pkg::ST_DSQ: begin
        mac_x = WW'(dmag);
        mac_y = dmag;
      end
      psm_pkg::ST_DNX: begin
        mac_x = rt_r;
        mac_y = nx;
      end
      psm_pkg::ST_DNY: begin
        mac_x    = rt_r;
        mac_y    = ny;
        mac_init = ra_r;
      end
      psm_pkg::ST_DEN: begin
        mac_x = WW'(n);
        mac_y = n_m1;
      end
      psm_pkg::ST_MX: begin
        mac_x = WW'(ux);
        mac_y = nx;
      end
      psm_pkg::ST_MY: begin
        mac_x    = WW'(uy);
        mac_y    = ny;
        mac_init = ra_r;
      end
      psm_pkg::ST_DIVV: begin
        dsq_num = ra_r;
        dsq_den = rt_r[psm_pkg::DEN_W-1:0];
      end
      psm_pkg::ST_SQRT: begin
        dsq_mode = psm_pkg::DSQ_SQRT;
        dsq_num  = WW'(rt_r[psm_pkg::SQ_W-1:0]);
      end
      psm_pkg::ST_DIVM: begin
        // (2*sum + n) / (2n) rounds to nearest
        dsq_num = {ra_r[WW-2:0], 1'b0} + WW'(n);
        dsq_den = psm_pkg::DEN_W'({n, 1'b0});
      end
      default: begin
      end
    endcase
    case (state_r)
      psm_pkg::ST_SXSQ, psm_pkg::ST_SXW, psm_pkg::ST_SYSQ, psm_pkg::ST_SYW,
      psm_pkg::ST_SCN, psm_pkg::ST_DSQ, psm_pkg::ST_DNX, psm_pkg::ST_DNY,
      psm_pkg::ST_DEN, psm_pkg::ST_MX, psm_pkg::ST_MY: begin
        mac_start = !issued_r;
        step_done = mac_sts.done;
      end
      psm_pkg::ST_DIVV, psm_pkg::ST_SQRT, psm_pkg::ST_DIVM: begin
        dsq_start = !issued_r;
        step_done = dsq_sts.done;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psm_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = have_r ? psm_pkg::ST_SXSQ : psm_pkg::ST_OUT;
        end
      end
      psm_pkg::ST_SXSQ: if (step_done) state_nxt = psm_pkg::ST_SXW;
      psm_pkg::ST_SXW:  if (step_done) state_nxt = psm_pkg::ST_SYSQ;
      psm_pkg::ST_SYSQ: if (step_done) state_nxt = psm_pkg::ST_SYW;
      psm_pkg::ST_SYW:  if (step_done) state_nxt = psm_pkg::ST_SCN;
      psm_pkg::ST_SCN:  if (step_done) state_nxt = psm_pkg::ST_DSQ;
      psm_pkg::ST_DSQ:  if (step_done) state_nxt = psm_pkg::ST_DNX;
      psm_pkg::ST_DNX:  if (step_done) state_nxt = psm_pkg::ST_DNY;
      psm_pkg::ST_DNY:  if (step_done) state_nxt = psm_pkg::ST_DEN;
      psm_pkg::ST_DEN:  if (step_done) state_nxt = psm_pkg::ST_DIVV;
      psm_pkg::ST_DIVV: if (step_done) state_nxt = psm_pkg::ST_SQRT;
      psm_pkg::ST_SQRT: if (step_done) state_nxt = psm_pkg::ST_MX;
      psm_pkg::ST_MX:   if (step_done) state_nxt = psm_pkg::ST_MY;
      psm_pkg::ST_MY:   if (step_done) state_nxt = psm_pkg::ST_DIVM;
      psm_pkg::ST_DIVM: if (step_done) state_nxt = psm_pkg::ST_OUT;
      psm_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = psm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = psm_pkg::ST_IDLE;
    endcase
  end

  // control and running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psm_pkg::ST_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
      run_mean_r  <= '0;
      run_sd_r    <= '0;
      run_count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) begin
        issued_r <= 1'b0;
      end else if (mac_start || dsq_start) begin
        issued_r <= 1'b1;
      end
      if (state_r == psm_pkg::ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
        if (last_r) begin
          have_r      <= 1'b0;
          run_mean_r  <= '0;
          run_sd_r    <= '0;
          run_count_r <= '0;
        end else begin
          have_r      <= 1'b1;
          run_mean_r  <= fin_mean;
          run_sd_r    <= fin_sd;
          run_count_r <= fin_count;
        end
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      gm_r   <= in_tdata[FW-1:0];
      gs_r   <= in_tdata[2*FW-1:FW];
      gc_r   <= in_tdata[3*FW-1:2*FW];
      last_r <= in_tlast;
      load_r <= !have_r;
    end
    if (mac_sts.done) begin
      case (state_r)
        psm_pkg::ST_SXSQ, psm_pkg::ST_SYSQ, psm_pkg::ST_DSQ,
        psm_pkg::ST_DNX, psm_pkg::ST_DEN: rt_r <= mac_p;
        default: ra_r <= mac_p;
      endcase
    end
    if (dsq_sts.done) begin
      case (state_r)
        psm_pkg::ST_DIVV: rt_r <= dsq_q;
        psm_pkg::ST_SQRT: begin
          if (n < LW'(2)) begin
            sd_new_r <= '0;
          end else if (rt_r[WW-1:psm_pkg::SQ_W] != '0) begin
            sd_new_r <= psm_pkg::CNT_MAX;
          end else begin
            sd_new_r <= dsq_root;
          end
        end
        default: begin
          mean_new_r <= (n == '0) ? run_mean_r
                                  : (dsq_q[FW-1:0] ^ psm_pkg::MEAN_FLIP);
        end
      endcase
    end
    if (state_r == psm_pkg::ST_OUT && out_free) begin
      out_data_r <= {fin_count, fin_sd, fin_mean};
      out_sat_r  <= (fin_count == psm_pkg::CNT_MAX);
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_sat_r;

  // busy for the whole merge once a group is taken
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input ready right after a transfer");

  // saturation flag agrees with the count it travels with
  a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[3*FW-1:2*FW] == psm_pkg::CNT_MAX))
    else $error("saturation flag without saturated count");

  // the sequencer never runs both units at once
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({mac_sts.busy, dsq_sts.busy}))
    else $error("multiplier and divider busy together");

endmodule

@@ tb/sv/tb_top.sv @@
// tb_top: self-checking testbench for pooled_mean_sd_merge.
// Needs psm_pkg and the pooled_mean_sd_merge RTL; the bench is self-contained.
//
// Directed groups from a table, then random sequences of groups. Each accepted
// input transfer is run through an exact wide-integer model of the pooled
// merge, and the result is queued. Output transfers are checked in order.
module tb_top;

  localparam int N_RANDOM = 1335;

  typedef struct packed {
    logic [31:0] mean;
    logic [31:0] sd;
    logic [31:0] cnt;
    logic        last;
  } group_t;

  typedef struct packed {
    logic [31:0] mean;
    logic [31:0] sd;
    logic [31:0] cnt;
    logic        sat;
    logic        fin;
  } summary_t;

  // stimulus row; the expected summary is only trusted when typed is set
  typedef struct packed {
    group_t   grp;
    logic     typed;
    summary_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [psm_pkg::TDATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [psm_pkg::TDATA_W-1:0] out_tdata;
  logic out_tlast;
  logic out_tuser;

  always #1 clk = ~clk;

  pooled_mean_sd_merge u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  // running summary mirrored by the bench
  logic [31:0] run_mean, run_sd, run_cnt;
  logic        run_loaded;
  summary_t    merged_q[$];
  int          errors = 0;
  int          in_idle_pct = 19;
  int          out_idle_pct = 19;

  function automatic logic [31:0] floor_sqrt64(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[31:0];
  endfunction

  // pooled sample sd; all products exact in 192 bits, divide floored
  function automatic logic [31:0] pooled_sd(logic [63:0] nx, logic [31:0] sx,
                                           logic [31:0] ux, logic [63:0] ny,
                                           logic [31:0] sy, logic [31:0] uy);
    logic [191:0] acc, dsq, den, q;
    logic [63:0]  n, wx, wy;
    logic [32:0]  mag;
    n = nx + ny;
    if (n < 2) return 32'd0;
    wx = (nx != 0) ? nx - 1 : 64'd0;
    wy = (ny != 0) ? ny - 1 : 64'd0;
    acc = 192'(sx) * 192'(sx) * 192'(wx) + 192'(sy) * 192'(sy) * 192'(wy);
    acc = acc * 192'(n);
    mag = (ux >= uy) ? 33'(ux) - 33'(uy) : 33'(uy) - 33'(ux);
    dsq = 192'(mag) * 192'(mag) * 192'(nx) * 192'(ny);
    acc = acc + dsq;
    den = 192'(n) * 192'(n - 1);
    q = acc / den;
    if (q[191:64] != 0) return psm_pkg::CNT_MAX;
    return floor_sqrt64(q[63:0]);
  endfunction

  // weighted mean on offset-binary values, rounded half up
  function automatic logic [31:0] weighted_mean(logic [63:0] nx, logic [31:0] ux,
                                               logic [63:0] ny, logic [31:0] uy);
    logic [191:0] s, q;
    logic [63:0]  n;
    n = nx + ny;
    if (n == 0) return ux;
    s = ((192'(ux) * 192'(nx) + 192'(uy) * 192'(ny)) << 1) + 192'(n);
    q = s / (192'(n) << 1);
    return q[31:0];
  endfunction

  function automatic summary_t merge_group(group_t g);
    summary_t    r;
    logic [63:0] nx, ny, n;
    logic [31:0] ux, uy;
    if (!run_loaded) begin
      run_mean = g.mean;
      run_sd = g.sd;
      run_cnt = g.cnt;
      run_loaded = 1'b1;
    end else begin
      nx = 64'(run_cnt);
      ny = 64'(g.cnt);
      n = nx + ny;
      ux = run_mean ^ psm_pkg::MEAN_FLIP;
      uy = g.mean ^ psm_pkg::MEAN_FLIP;
      run_sd = pooled_sd(nx, run_sd, ux, ny, g.sd, uy);
      run_mean = weighted_mean(nx, ux, ny, uy) ^ psm_pkg::MEAN_FLIP;
      run_cnt = (n > 64'(psm_pkg::CNT_MAX)) ? psm_pkg::CNT_MAX : n[31:0];
    end
    r.mean = run_mean;
    r.sd = run_sd;
    r.cnt = run_cnt;
    r.sat = (run_cnt == psm_pkg::CNT_MAX);
    r.fin = g.last;
    if (g.last) begin
      run_mean = '0;
      run_sd = '0;
      run_cnt = '0;
      run_loaded = 1'b0;
    end
    return r;
  endfunction

  // one input transfer, with random idle cycles in front; the prediction is
  // taken at the accepting edge
  task automatic send_group(group_t g, logic typed, summary_t want);
    summary_t p;
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {g.cnt, g.sd, g.mean};
    in_tlast <= g.last;
    do @(posedge clk); while (!in_tready);
    p = merge_group(g);
    if (typed && p != want) begin
      $error("table row disagrees with model: want %h got %h", want, p);
      errors++;
    end
    merged_q.insert(merged_q.size(), p);
  endtask

  task automatic wait_drained();
    while (merged_q.size() != 0) @(posedge clk);
  endtask

  // output side: random back-pressure, checker on every transfer
  always @(posedge clk) begin
    summary_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (merged_q.size() == 0) begin
        $error("unexpected result transfer %h", out_tdata);
        errors++;
      end else begin
        e = merged_q.pop_front();
        if (out_tdata[31:0] !== e.mean) begin
          $error("merged_mean: expected %h actual %h", e.mean, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[63:32] !== e.sd) begin
          $error("merged_sd: expected %h actual %h", e.sd, out_tdata[63:32]);
          errors++;
        end
        if (out_tdata[95:64] !== e.cnt) begin
          $error("merged_count: expected %h actual %h", e.cnt, out_tdata[95:64]);
          errors++;
        end
        if (out_tuser !== e.sat) begin
          $error("count_saturated: expected %b actual %b", e.sat, out_tuser);
          errors++;
        end
        if (out_tlast !== e.fin) begin
          $error("final_result: expected %b actual %b", e.fin, out_tlast);
          errors++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // directed rows: {mean, sd, count, last}, typed, {mean, sd, count, sat, fin}
  localparam int N_DIR = 16;
  dir_row_t dir_tab [N_DIR] = '{
    // single group passes through: extremes of mean and sd
    '{'{32'h8000_0000, 32'hFFFF_FFFF, 32'd1, 1'b1}, 1'b1,
      '{32'h8000_0000, 32'hFFFF_FFFF, 32'd1, 1'b0, 1'b1}},
    // single group at the count limit raises the flag
    '{'{32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b1}, 1'b1,
      '{32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1}},
    // two single samples 0 and 2: mean 1, sd 1
    '{'{32'd0, 32'd0, 32'd1, 1'b0}, 1'b1, '{32'd0, 32'd0, 32'd1, 1'b0, 1'b0}},
    '{'{32'd2, 32'd0, 32'd1, 1'b1}, 1'b1, '{32'd1, 32'd1, 32'd2, 1'b0, 1'b1}},
    // half-way mean rounds up
    '{'{32'd0, 32'd0, 32'd1, 1'b0}, 1'b0, '0},
    '{'{32'd1, 32'd0, 32'd1, 1'b1}, 1'b0, '0},
    // negative half-way
    '{'{32'hFFFF_FFFF, 32'd0, 32'd1, 1'b0}, 1'b0, '0},
    '{'{32'hFFFF_FFFE, 32'd0, 32'd1, 1'b1}, 1'b0, '0},
    // count overflow, then saturated count reused
    '{'{32'h0001_0000, 32'h0002_0000, 32'hFFFF_FFF0, 1'b0}, 1'b0, '0},
    '{'{32'hFFFF_0000, 32'h0000_8000, 32'h0000_0100, 1'b0}, 1'b0, '0},
    '{'{32'h0000_1234, 32'h0003_0000, 32'd7, 1'b1}, 1'b0, '0},
    // large deviation saturates the sd
    '{'{32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}, 1'b0, '0},
    '{'{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b0, '0},
    // three-group sequence with ordinary values
    '{'{32'h0005_0000, 32'h0001_0000, 32'd10, 1'b0}, 1'b0, '0},
    '{'{32'hFFFD_0000, 32'h0002_8000, 32'd20, 1'b0}, 1'b0, '0},
    '{'{32'h0000_8000, 32'h0000_4000, 32'd5, 1'b1}, 1'b0, '0}
  };

  function automatic logic [31:0] rand_count();
    case ($urandom_range(9))
      0:       return $urandom_range(32'hFFFF_FFFF, 32'hFFFF_F000);
      1:       return $urandom() | 32'd1;
      2:       return 32'd1;
      default: return $urandom_range(1000, 1);
    endcase
  endfunction

  initial begin
    group_t g;
    int     seq_len, sent;
    run_mean = '0; run_sd = '0; run_cnt = '0; run_loaded = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_group(dir_tab[i].grp, dir_tab[i].typed, dir_tab[i].want);

    // hold the sender until the block has drained
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait_drained();

    sent = 0;
    while (sent < N_RANDOM) begin
      seq_len = $urandom_range(6, 1);
      for (int k = 0; k < seq_len && sent < N_RANDOM; k++) begin
        // a run of transfers with no idling on either side
        if (sent == 400) begin
          in_idle_pct = 0;
          out_idle_pct = 0;
        end
        if (sent == 650) begin
          in_idle_pct = 19;
          out_idle_pct = 19;
        end
        g.mean = $urandom_range(1) ? $urandom() : $urandom_range(32'h0010_0000) - 32'h0008_0000;
        g.sd = $urandom_range(3) == 0 ? $urandom() : $urandom_range(32'h0004_0000);
        g.cnt = rand_count();
        g.last = (k == seq_len - 1) || (sent == N_RANDOM - 1) || ($urandom_range(15) == 0);
        send_group(g, 1'b0, '0);
        sent++;
        if (sent == 800) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
          wait_drained();
        end
        if (g.last) break;
      end
    end
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
    wait_drained();
    repeat (500) @(posedge clk);
    if (errors == 0 && merged_q.size() == 0) begin
      $display("PASS pooled_mean_sd_merge");
    end else begin
      $display("FAIL pooled_mean_sd_merge");
    end
    $finish;
  end

  // watchdog: roughly 8x the slowest plausible run
  initial begin
    #8000000;
    $display("FAIL pooled_mean_sd_merge");
    $finish;
  end

endmodule

@@ filelist.f @@
design/psm_pkg.sv
design/psm_mac.sv
design/psm_dsq.sv
design/pooled_mean_sd_merge.sv
tb/sv/tb_top.sv
